// ===== hw/rtl/http_chunked_body_decoder_defines.svh =====
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define HCBD_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define HCBD_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define HCBD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int unsigned SIZE_BITS_DEFAULT = 31;
    localparam int unsigned BYTE_BITS         = 8;
    localparam int unsigned KIND_BITS         = 2;
    // one hex digit carries a factor of 16
    localparam int unsigned HEX_DIGIT_BITS    = 4;

    localparam logic [KIND_BITS-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_BAD  = 2'd2;

    localparam logic [BYTE_BITS-1:0] CHAR_HT    = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_VT    = 8'h0B;
    localparam logic [BYTE_BITS-1:0] CHAR_FF    = 8'h0C;
    localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_SP    = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [BYTE_BITS-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_BITS-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_BITS-1:0] CHAR_UA    = 8'h41;
    localparam logic [BYTE_BITS-1:0] CHAR_UF    = 8'h46;
    localparam logic [BYTE_BITS-1:0] CHAR_LA    = 8'h61;
    localparam logic [BYTE_BITS-1:0] CHAR_LF_HEX = 8'h66;

    typedef struct packed {
        logic                      is_blank;
        logic                      is_hex;
        logic                      is_semi;
        logic                      is_cr;
        logic                      is_lf;
        logic [HEX_DIGIT_BITS-1:0] hex_val;
    } byte_class_t;

endpackage

// ===== hw/rtl/hcbd_body_if.sv =====
`timescale 1ns / 1ps

interface hcbd_body_if import hcbd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] body_byte;
    logic                 first_byte;

    modport source (output valid, output body_byte, output first_byte, input ready);
    modport sink   (input valid, input body_byte, input first_byte, output ready);
endinterface

// ===== hw/rtl/hcbd_result_if.sv =====
`timescale 1ns / 1ps

interface hcbd_result_if import hcbd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [BYTE_BITS-1:0] payload_byte;

    modport source (output valid, output kind, output payload_byte, input ready);
    modport sink   (input valid, input kind, input payload_byte, output ready);
endinterface

// ===== hw/rtl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

// HTTP/1.1 chunked body decoder. Takes one body byte per cycle and removes the
// chunk framing: size lines (hex size, blanks, optional ';' extension, CR LF)
// are consumed, data bytes come out as kind 0, the zero chunk plus two bytes
// ends the body with kind 1, and a malformed size line ends it with kind 2 when
// its CR LF arrives. first_byte restarts the parser on that byte. The parser
// state is updated in a single step and a result appears on the output
// register in the cycle after its byte is accepted. The output register lets
// the next byte in while a result waits, so the input is stalled only while a
// result is held and the output sink is not ready. After the body has ended
// bytes are taken and dropped until first_byte is set.

`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    hcbd_body_if.sink     body,
    hcbd_result_if.source result
);

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_TRAIL  = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_LAST   = 3'd6;
    localparam logic [2:0] PH_BAD    = 3'd7;

    localparam logic [SIZE_BITS-1:0] COUNT_TWO = SIZE_BITS'(2);

    logic [2:0]           phase_reg,       phase_next;
    logic [SIZE_BITS-1:0] count_reg,       count_next;
    logic                 digit_seen_reg,  digit_seen_next;
    logic                 cr_pending_reg,  cr_pending_next;
    logic                 finished_reg,    finished_next;
    logic                 out_valid_reg,   out_valid_next;
    logic [KIND_BITS-1:0] out_kind_reg,    out_kind_next;
    logic [BYTE_BITS-1:0] out_byte_reg,    out_byte_next;

    logic                 in_fire;
    logic                 res_valid;
    logic [KIND_BITS-1:0] res_kind;
    byte_class_t          cls;

    hcbd_classify u_classify
    (
        .byte_in (body.body_byte),
        .cls     (cls)
    );

    assign body.ready         = !out_valid_reg || result.ready;
    assign in_fire            = body.valid && body.ready;
    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.payload_byte = out_byte_reg;

    always_comb
    begin
        logic [2:0]           ph;
        logic [SIZE_BITS-1:0] cnt;
        logic [SIZE_BITS-1:0] cnt_dec;
        logic                 dig;
        logic                 crp;
        logic                 fin;

        ph  = phase_reg;
        cnt = count_reg;
        dig = digit_seen_reg;
        crp = cr_pending_reg;
        fin = finished_reg;

        // restart on the first byte of a new body
        if (body.first_byte)
        begin
            ph  = PH_LEAD;
            cnt = '0;
            dig = 1'b0;
            crp = 1'b0;
            fin = 1'b0;
        end

        cnt_dec   = cnt - SIZE_BITS'(1);
        res_valid = 1'b0;
        res_kind  = KIND_DATA;

        if (!fin)
        begin
            case (ph)
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (cnt_dec == '0)
                    begin
                        ph  = PH_SKIP;
                        cnt = COUNT_TWO;
                    end
                    else
                    begin
                        cnt = cnt_dec;
                    end
                end
                PH_SKIP:
                begin
                    cnt = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        ph  = PH_LEAD;
                        dig = 1'b0;
                        crp = 1'b0;
                    end
                end
                PH_LAST:
                begin
                    cnt = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        fin       = 1'b1;
                        res_valid = 1'b1;
                        res_kind  = KIND_DONE;
                    end
                end
                default:
                begin
                    if (cls.is_lf && crp)
                    begin
                        crp = 1'b0;
                        if (ph == PH_BAD || !dig)
                        begin
                            fin       = 1'b1;
                            res_valid = 1'b1;
                            res_kind  = KIND_BAD;
                        end
                        else if (cnt == '0)
                        begin
                            ph  = PH_LAST;
                            cnt = COUNT_TWO;
                        end
                        else
                        begin
                            ph = PH_DATA;
                        end
                    end
                    else
                    begin
                        crp = cls.is_cr;
                        if (ph == PH_EXT || ph == PH_BAD)
                        begin
                            // skip extension text and the rest of a bad line
                        end
                        else if (cls.is_semi)
                        begin
                            ph = PH_EXT;
                        end
                        else if (cls.is_blank)
                        begin
                            if (ph == PH_DIGITS)
                            begin
                                ph = PH_TRAIL;
                            end
                        end
                        else if (!cls.is_hex || ph == PH_TRAIL)
                        begin
                            ph = PH_BAD;
                        end
                        else if (cnt[SIZE_BITS-1 -: HEX_DIGIT_BITS] != '0)
                        begin
                            ph = PH_BAD;
                        end
                        else
                        begin
                            cnt = {cnt[SIZE_BITS-HEX_DIGIT_BITS-1:0], cls.hex_val};
                            dig = 1'b1;
                            ph  = PH_DIGITS;
                        end
                    end
                end
            endcase
        end

        phase_next      = phase_reg;
        count_next      = count_reg;
        digit_seen_next = digit_seen_reg;
        cr_pending_next = cr_pending_reg;
        finished_next   = finished_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;

        if (in_fire)
        begin
            phase_next      = ph;
            count_next      = cnt;
            digit_seen_next = dig;
            cr_pending_next = crp;
            finished_next   = fin;
            out_valid_next  = res_valid;
            if (res_valid)
            begin
                out_kind_next = res_kind;
                out_byte_next = (res_kind == KIND_DATA) ? body.body_byte : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            count_reg      <= '0;
            digit_seen_reg <= 1'b0;
            cr_pending_reg <= 1'b0;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            digit_seen_reg <= digit_seen_next;
            cr_pending_reg <= cr_pending_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
    end

    `HCBD_ASSERT_IMPLIES(a_no_result_after_end, clk, rst_n, finished_reg && !body.first_byte, !res_valid, "result produced after body ended")
    `HCBD_ASSERT_IMPLIES(a_data_count_live, clk, rst_n, phase_reg == PH_DATA && !finished_reg, count_reg != '0, "data phase with zero bytes left")
    `HCBD_ASSERT_IMPLIES(a_lead_clean, clk, rst_n, phase_reg == PH_LEAD, count_reg == '0 && !digit_seen_reg, "size line start not cleared")
    `HCBD_ASSERT_IMPLIES(a_framing_zero_byte, clk, rst_n, out_valid_reg && out_kind_reg != KIND_DATA, out_byte_reg == '0, "end marker carries a payload byte")

endmodule

// ===== hw/rtl/hcbd_classify.sv =====
`timescale 1ns / 1ps

module hcbd_classify import hcbd_pkg::*;
(
    input  logic [BYTE_BITS-1:0] byte_in,
    output byte_class_t          cls
);

    logic is_digit;
    logic is_upper;
    logic is_lower;

    always_comb
    begin
        is_digit = byte_in inside {[CHAR_0:CHAR_9]};
        is_upper = byte_in inside {[CHAR_UA:CHAR_UF]};
        is_lower = byte_in inside {[CHAR_LA:CHAR_LF_HEX]};

        cls.is_blank = byte_in inside {CHAR_SP, CHAR_HT, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
        cls.is_hex   = is_digit | is_upper | is_lower;
        cls.is_semi  = (byte_in == CHAR_SEMI);
        cls.is_cr    = (byte_in == CHAR_CR);
        cls.is_lf    = (byte_in == CHAR_LF);

        // letters: low nibble 1..6 maps to 10..15
        if (is_digit)
        begin
            cls.hex_val = byte_in[HEX_DIGIT_BITS-1:0];
        end
        else if (is_upper || is_lower)
        begin
            cls.hex_val = byte_in[HEX_DIGIT_BITS-1:0] + 4'd9;
        end
        else
        begin
            cls.hex_val = '0;
        end
    end

endmodule
